FILE: rtl/rmslm_pkg.sv
// rmslm_pkg: widths, constants and the block summary type of the rms level meter
// depends on nothing; every other file imports it
package rmslm_pkg;

   localparam int DataWidth      = 8;
   localparam int FullScaleWidth = 8;
   localparam int LevelWidth     = 16;

   localparam int MaxSamples     = 4096;
   localparam int CountWidth     = $clog2(MaxSamples + 1);

   // a square is at most 2**30, so a mean fits 31 bits
   localparam int SquareWidth    = 32;
   localparam int MeanWidth      = 31;
   localparam int SumWidth       = MeanWidth + $clog2(MaxSamples);

   // divider: one quotient bit a step
   localparam int DivSteps       = SumWidth;
   localparam int DivStepWidth   = $clog2(DivSteps);

   // root of mean * 65536: two radicand bits a step
   localparam int MeanShift      = 16;
   localparam int RadWidth       = MeanWidth + MeanShift + 1;
   localparam int RootWidth      = RadWidth / 2;
   localparam int SqrtSteps      = RootWidth;
   localparam int SqrtStepWidth  = $clog2(SqrtSteps);
   localparam int SqrtRemWidth   = RootWidth + 2;

   localparam int ProdWidth      = RootWidth + FullScaleWidth;
   localparam int LevelShift     = 15;

   localparam logic [FullScaleWidth-1:0] FullScaleReset = 8'd200;
   localparam logic [LevelWidth-1:0]     LevelMax       = 16'hFF00;

   localparam int QueueDepth      = 2;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [SumWidth-1:0]   sum;
      logic [CountWidth-1:0] count;
   } rmslm_block_type;

endpackage

FILE: rtl/rmslm_if.sv
// rmslm channel interfaces: byte input, level result, configuration write
// depends on rmslm_pkg for the field widths
interface rmslm_req_if import rmslm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] data_byte;
   logic                 last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface rmslm_rsp_if import rmslm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [LevelWidth-1:0] level;
   logic [CountWidth-1:0] sample_count;

   modport source (output valid, output level, output sample_count, input ready);
   modport sink   (input valid, input level, input sample_count, output ready);
endinterface

interface rmslm_csr_if import rmslm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FullScaleWidth-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rmslm_front.sv
// rmslm_front: pairs bytes into samples and accumulates squares and count per block
// depends on rmslm_pkg and rmslm_req_if; hands a block summary to the queue
module rmslm_front import rmslm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   rmslm_req_if.sink       req_bus,
   output logic            blk_valid,
   input  logic            blk_ready,
   output rmslm_block_type blk_data
);

   logic [DataWidth-1:0]   held_ff, held_in;
   logic                   phase_ff, phase_in;
   logic [SumWidth-1:0]    sum_ff, sum_in;
   logic [SquareWidth-1:0] sq_ff, sq_in;
   logic                   sq_valid_ff, sq_valid_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   emit_ff, emit_in;

   logic                   advance;
   logic                   accept;
   logic                   take;
   logic [15:0]            raw;
   logic [15:0]            mag;
   logic [SumWidth-1:0]    sum_total;
   logic [SumWidth-1:0]    base_sum;
   logic [CountWidth-1:0]  base_count;

   // the pending square waits in sq_ff and joins the sum through sum_total
   assign sum_total = sum_ff + (sq_valid_ff ? SumWidth'(sq_ff) : '0);

   assign advance       = !emit_ff || blk_ready;
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;

   assign blk_valid      = emit_ff;
   assign blk_data.sum   = sum_total;
   assign blk_data.count = count_ff;

   assign raw  = {req_bus.data_byte, held_ff};
   assign mag  = raw[15] ? 16'(~raw + 16'd1) : raw;

   always_comb begin
      if (emit_ff) begin
         base_sum   = '0;
         base_count = '0;
      end else begin
         base_sum   = sum_total;
         base_count = count_ff;
      end
   end

   // samples past the limit are dropped
   assign take = accept && phase_ff && (base_count < CountWidth'(MaxSamples));

   always_comb begin
      held_in     = held_ff;
      phase_in    = phase_ff;
      sum_in      = sum_ff;
      sq_in       = sq_ff;
      sq_valid_in = sq_valid_ff;
      count_in    = count_ff;
      emit_in     = emit_ff;
      if (advance) begin
         sum_in      = base_sum;
         count_in    = base_count + CountWidth'(take);
         sq_valid_in = take;
         sq_in       = SquareWidth'(mag) * SquareWidth'(mag);
         emit_in     = accept && req_bus.last;
         if (accept) begin
            if (!phase_ff) begin
               held_in  = req_bus.data_byte;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
            end
            if (req_bus.last) begin
               phase_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 1'b0;
         sum_ff      <= '0;
         sq_valid_ff <= 1'b0;
         count_ff    <= '0;
         emit_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         sum_ff      <= sum_in;
         sq_valid_ff <= sq_valid_in;
         count_ff    <= count_in;
         emit_ff     <= emit_in;
      end
      held_ff <= held_in;
      sq_ff   <= sq_in;
   end

   // a finished block waits in place until the queue takes it
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      emit_ff && !blk_ready |=> emit_ff && $stable(count_ff))
      else $error("block summary dropped while queue was full");

endmodule

FILE: rtl/rmslm_queue.sv
// rmslm_queue: two-entry queue of block summaries between front and back
// depends on rmslm_pkg
module rmslm_queue import rmslm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  rmslm_block_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rmslm_block_type out_data
);

   rmslm_block_type             slot_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0]  count_ff, count_in;
   logic                        push;
   logic                        pop;

   assign in_ready  = count_ff != QueueCountWidth'(QueueDepth);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QueueCountWidth'(push) - QueueCountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCountWidth'(QueueDepth))
      else $error("queue fill count out of range");

endmodule

FILE: rtl/rmslm_back.sv
// rmslm_back: per-block divide, square root and scaling, with the result register
// depends on rmslm_pkg, rmslm_rsp_if and rmslm_csr_if; holds the full_scale register
module rmslm_back import rmslm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   rmslm_csr_if.sink       csr_bus,
   input  logic            blk_valid,
   output logic            blk_ready,
   input  rmslm_block_type blk_data,
   rmslm_rsp_if.source     rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ROOT,
      ST_MULTIPLY,
      ST_DELIVER
   } state_type;

   state_type                 state_ff, state_in;
   logic [FullScaleWidth-1:0] fs_ff, fs_in;
   logic [SumWidth-1:0]       num_ff, num_in;
   logic [CountWidth-1:0]     den_ff, den_in;
   logic [CountWidth-1:0]     drem_ff, drem_in;
   logic [DivStepWidth-1:0]   dstep_ff, dstep_in;
   logic [RadWidth-1:0]       rad_ff, rad_in;
   logic [SqrtRemWidth-1:0]   srem_ff, srem_in;
   logic [RootWidth-1:0]      root_ff, root_in;
   logic [SqrtStepWidth-1:0]  sstep_ff, sstep_in;
   logic [ProdWidth-1:0]      prod_ff, prod_in;
   logic [CountWidth-1:0]     hold_count_ff, hold_count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LevelWidth-1:0]     level_ff, level_in;
   logic [CountWidth-1:0]     rsp_count_ff, rsp_count_in;

   logic [CountWidth:0]       dtrial;
   logic                      dfit;
   logic [CountWidth:0]       ddiff;
   logic [SumWidth-1:0]       div_q;
   logic [SqrtRemWidth+1:0]   strial_rem;
   logic [SqrtRemWidth+1:0]   strial;
   logic                      sfit;
   logic [SqrtRemWidth+1:0]   sdiff;

   assign csr_bus.ready = 1'b1;
   assign blk_ready     = state_ff == ST_IDLE;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.level        = level_ff;
   assign rsp_bus.sample_count = rsp_count_ff;

   // restoring division step
   assign dtrial = {drem_ff, num_ff[SumWidth-1]};
   assign dfit   = dtrial >= {1'b0, den_ff};
   assign ddiff  = dtrial - {1'b0, den_ff};
   assign div_q  = {num_ff[SumWidth-2:0], dfit};

   // digit-by-digit root step
   assign strial_rem = {srem_ff, rad_ff[RadWidth-1 -: 2]};
   assign strial     = (SqrtRemWidth+2)'({root_ff, 2'b01});
   assign sfit       = strial_rem >= strial;
   assign sdiff      = strial_rem - strial;

   always_comb begin
      state_in      = state_ff;
      fs_in         = fs_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      drem_in       = drem_ff;
      dstep_in      = dstep_ff;
      rad_in        = rad_ff;
      srem_in       = srem_ff;
      root_in       = root_ff;
      sstep_in      = sstep_ff;
      prod_in       = prod_ff;
      hold_count_in = hold_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      level_in      = level_ff;
      rsp_count_in  = rsp_count_ff;

      if (csr_bus.valid) begin
         fs_in = csr_bus.data;
      end
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (blk_valid) begin
               num_in        = blk_data.sum;
               den_in        = blk_data.count;
               hold_count_in = blk_data.count;
               drem_in       = '0;
               dstep_in      = '0;
               if (blk_data.count == '0) begin
                  // empty block reports level zero
                  root_in  = '0;
                  state_in = ST_MULTIPLY;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            num_in   = div_q;
            drem_in  = dfit ? ddiff[CountWidth-1:0] : dtrial[CountWidth-1:0];
            dstep_in = dstep_ff + 1'b1;
            if (dstep_ff == DivStepWidth'(DivSteps - 1)) begin
               rad_in   = RadWidth'({div_q[MeanWidth-1:0], {MeanShift{1'b0}}});
               srem_in  = '0;
               root_in  = '0;
               sstep_in = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rad_in   = {rad_ff[RadWidth-3:0], 2'b00};
            srem_in  = sfit ? sdiff[SqrtRemWidth-1:0] : strial_rem[SqrtRemWidth-1:0];
            root_in  = {root_ff[RootWidth-2:0], sfit};
            sstep_in = sstep_ff + 1'b1;
            if (sstep_ff == SqrtStepWidth'(SqrtSteps - 1)) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            prod_in  = ProdWidth'(root_ff) * ProdWidth'(fs_ff);
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               level_in     = prod_ff[LevelShift +: LevelWidth];
               rsp_count_in = hold_count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fs_ff        <= FullScaleReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fs_ff        <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff        <= num_in;
      den_ff        <= den_in;
      drem_ff       <= drem_in;
      dstep_ff      <= dstep_in;
      rad_ff        <= rad_in;
      srem_ff       <= srem_in;
      root_ff       <= root_in;
      sstep_ff      <= sstep_in;
      prod_ff       <= prod_in;
      hold_count_ff <= hold_count_in;
      level_ff      <= level_in;
      rsp_count_ff  <= rsp_count_in;
   end

   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_count_ff == '0) |-> level_ff == '0)
      else $error("empty block gave a nonzero level");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (level_ff <= LevelMax) &&
                       (rsp_count_ff <= CountWidth'(MaxSamples)))
      else $error("result out of range");

endmodule

FILE: rtl/rms_audio_level_meter_unit.sv
// rms_audio_level_meter_unit: top level of the rms audio level meter
// depends on rmslm_pkg, rmslm_if, rmslm_front, rmslm_queue and rmslm_back
//
//   port     dir   carries                              accepted when
//   req_bus  in    data_byte[7:0], last                 valid && ready
//   rsp_bus  out   level[15:0] q8.8, sample_count[12:0] valid && ready
//   csr_bus  in    data[7:0] -> full_scale              valid && ready (ready tied high)
//
// the front takes one byte a cycle; it stalls only when a finished block
// cannot enter the full two-entry queue
// the back works on one block at a time: it loads the block, runs 43 divider
// steps (one quotient bit each) and 24 root steps (two radicand bits each), then
// multiplies and loads the result register; an empty block skips divide and root
// synchronous active-high reset clears the accumulator, the queue and the result
// valid flag and sets full_scale to 200; no clearing pass is needed
module rms_audio_level_meter_unit import rmslm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rmslm_req_if.sink   req_bus,
   rmslm_rsp_if.source rsp_bus,
   rmslm_csr_if.sink   csr_bus
);

   // front to queue
   logic            acc_valid;
   logic            acc_ready;
   rmslm_block_type acc_data;

   // queue to back
   logic            work_valid;
   logic            work_ready;
   rmslm_block_type work_data;

   // byte pairing, squaring and per-block sums
   rmslm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .blk_valid (acc_valid),
      .blk_ready (acc_ready),
      .blk_data  (acc_data)
   );

   // lets the front run on while the back is busy with an earlier block
   rmslm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_ready  (acc_ready),
      .in_data   (acc_data),
      .out_valid (work_valid),
      .out_ready (work_ready),
      .out_data  (work_data)
   );

   // mean, root and scaling; owns full_scale and the result register
   rmslm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_bus   (csr_bus),
      .blk_valid (work_valid),
      .blk_ready (work_ready),
      .blk_data  (work_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: bench/tb_rms_audio_level_meter_unit.sv
`timescale 1ns / 100ps
// tb_rms_audio_level_meter_unit: self-checking bench for the rms audio level meter
// depends on rmslm_pkg, the rmslm channel interfaces and rms_audio_level_meter_unit
// a directed table, then random audio blocks checked against an in-bench level predictor
module tb_rms_audio_level_meter_unit;
   import rmslm_pkg::*;

   // one level reading as the block reports it
   typedef struct packed {
      logic [LevelWidth-1:0] level;
      logic [CountWidth-1:0] count;
   } meter_reading_type;

   // one row of the directed table; reps repeats the byte, last goes on the final copy
   typedef struct packed {
      bit                        set_scale;
      logic [FullScaleWidth-1:0] scale;
      logic [DataWidth-1:0]      data;
      bit                        is_last;
      int                        reps;
      bit                        typed;
      logic [LevelWidth-1:0]     level;
      logic [CountWidth-1:0]     count;
   } stim_row_type;

   localparam int RowCount      = 21;
   localparam int RandomItems   = 1200;
   localparam int CalmAfter     = 1000;
   localparam int SettleCycles  = 80;
   localparam int HoldOffCycles = 700;

   localparam stim_row_type DirectedRows [RowCount] = '{
      // full_scale at its reset value
      '{1'b0, 8'd0,   8'h5A, 1'b1, 1,    1'b1, 16'd0,     13'd0}, // lone odd byte: empty block
      '{1'b0, 8'd0,   8'h00, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h00, 1'b1, 1,    1'b1, 16'd0,     13'd1}, // one silent sample
      '{1'b0, 8'd0,   8'hFF, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h7F, 1'b1, 1,    1'b0, 16'd0,     13'd0}, // largest positive sample
      '{1'b0, 8'd0,   8'h01, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h00, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h37, 1'b1, 1,    1'b0, 16'd0,     13'd0}, // trailing low byte dropped
      '{1'b0, 8'd0,   8'h80, 1'b1, 301,  1'b0, 16'd0,     13'd0}, // long block, odd tail
      // loudest setting
      '{1'b1, 8'd255, 8'h00, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h80, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h00, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h80, 1'b1, 1,    1'b1, LevelMax,  13'd2}, // full-scale negative
      '{1'b0, 8'd0,   8'hFF, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'hFF, 1'b1, 1,    1'b0, 16'd0,     13'd0}, // minus one
      // quietest setting
      '{1'b1, 8'd1,   8'h00, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h80, 1'b1, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h01, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h00, 1'b1, 1,    1'b0, 16'd0,     13'd0},
      // zero full scale forces a zero level
      '{1'b1, 8'd0,   8'h00, 1'b0, 1,    1'b0, 16'd0,     13'd0},
      '{1'b0, 8'd0,   8'h80, 1'b1, 1,    1'b1, 16'd0,     13'd1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmslm_req_if req_bus ();
   rmslm_rsp_if rsp_bus ();
   rmslm_csr_if csr_bus ();

   rms_audio_level_meter_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state: the block being accumulated and the live full_scale
   logic [DataWidth-1:0]      pending_low  = '0;
   bit                        high_next    = 1'b0;
   longint unsigned           energy_sum   = 0;
   int                        sample_tally = 0;
   logic [FullScaleWidth-1:0] scale_now    = FullScaleReset;

   meter_reading_type levels_due [$];
   int  mismatches    = 0;
   int  bytes_fed     = 0;
   bit  sender_gaps   = 1'b1;
   bit  answer_stalls = 1'b1;
   bit  calm          = 1'b0;   // no idling on either side near the end
   bit  hold_req      = 1'b0;   // asks the receiver for one long hold-off

   // floor square root, one result bit at a time from the top
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int k = 24; k >= 0; k--) begin
         trial = root | (64'd1 << k);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // advance the predictor by one byte; fire says a level reading is due
   function automatic void predict_level(input logic [DataWidth-1:0] b, input logic is_last,
                                         output bit fire, output meter_reading_type reading);
      logic [15:0]     word;
      longint unsigned mag;
      longint unsigned mean;
      longint unsigned root;
      reading = '0;
      if (!high_next) begin
         pending_low = b;
         high_next   = 1'b1;
      end else begin
         word      = {b, pending_low};
         mag       = word[15] ? 64'd65536 - word : 64'(word);
         high_next = 1'b0;
         // samples past the limit are neither squared nor counted
         if (sample_tally < MaxSamples) begin
            energy_sum   += mag * mag;
            sample_tally += 1;
         end
      end
      fire = is_last;
      if (is_last) begin
         if (sample_tally != 0) begin
            mean          = energy_sum / sample_tally;
            root          = floor_sqrt(mean << 16);
            reading.level = LevelWidth'((root * scale_now) >> LevelShift);
         end
         reading.count = CountWidth'(sample_tally);
         pending_low   = '0;
         high_next     = 1'b0;
         energy_sum    = 0;
         sample_tally  = 0;
      end
   endfunction

   // offer one byte, wait for the handshake, then book the expected reading
   task automatic feed_byte(input logic [DataWidth-1:0] b, input logic is_last, input bit typed,
                            input logic [LevelWidth-1:0] lvl, input logic [CountWidth-1:0] cnt);
      bit                fire;
      meter_reading_type want;
      if (!calm && sender_gaps && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last      <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_level(b, is_last, fire, want);
      if (fire) begin
         // typed rows carry a hand-worked reading instead of the predicted one
         if (typed) begin
            want.level = lvl;
            want.count = cnt;
         end
         levels_due.push_back(want);
      end
      bytes_fed++;
   endtask

   // one random audio block; style 0 is noise, 1 loud, 2 quiet
   task automatic feed_block(input int pairs, input bit odd, input int style);
      int                   n;
      logic [DataWidth-1:0] b;
      n = 2 * pairs + (odd ? 1 : 0);
      if (n == 0) n = 1;
      for (int i = 0; i < n; i++) begin
         b = DataWidth'($urandom);
         if (i % 2 == 1) begin
            case (style)
               1: b = ($urandom_range(0, 1) == 0) ? 8'h80 : 8'h7F;
               2: b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
               default: ;
            endcase
         end
         feed_byte(b, i == n - 1, 1'b0, '0, '0);
      end
   endtask

   // stop offering, let every reading come back and the back end go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_scale(input logic [FullScaleWidth-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      scale_now = value;
   endtask

   // result side: ready with random stall bursts and one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b1;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else if (!calm && answer_stalls && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare every accepted reading with the oldest one due
   always @(posedge clock) begin
      meter_reading_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (levels_due.size() == 0) begin
            $error("unexpected reading: level %0d, sample_count %0d",
                   rsp_bus.level, rsp_bus.sample_count);
            mismatches++;
         end else begin
            want = levels_due.pop_front();
            if (rsp_bus.level !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, rsp_bus.level);
               mismatches++;
            end
            if (rsp_bus.sample_count !== want.count) begin
               $error("sample_count: expected %0d, got %0d", want.count, rsp_bus.sample_count);
               mismatches++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int random_start;
      int phase;
      logic [FullScaleWidth-1:0] scale;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last      = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.data      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table, full_scale changes only on a quiet block
      for (int r = 0; r < RowCount; r++) begin
         if (DirectedRows[r].set_scale) begin
            settle();
            write_scale(DirectedRows[r].scale);
         end
         for (int k = 0; k < DirectedRows[r].reps; k++) begin
            feed_byte(DirectedRows[r].data,
                      DirectedRows[r].is_last && (k == DirectedRows[r].reps - 1),
                      DirectedRows[r].typed, DirectedRows[r].level, DirectedRows[r].count);
         end
      end

      // random phases, each with its own full_scale and idling mix
      random_start = bytes_fed;
      phase = 0;
      while (phase < 3 || bytes_fed - random_start < RandomItems) begin
         settle();
         case (phase)
            0:       scale = 8'd255;
            1:       scale = 8'd1;
            default: scale = FullScaleWidth'($urandom_range(1, 255));
         endcase
         write_scale(scale);
         sender_gaps   = ($urandom_range(0, 3) != 0);
         answer_stalls = ($urandom_range(0, 3) != 0);
         if (bytes_fed - random_start >= CalmAfter) calm = 1'b1;
         if (phase == 2) begin
            // short blocks against a stalled receiver: queue fills, input stalls
            sender_gaps = 1'b0;
            hold_req    = 1'b1;
            repeat (40) feed_block(1, 1'b0, $urandom_range(0, 2));
         end else begin
            repeat ($urandom_range(6, 14)) begin
               if (bytes_fed - random_start >= CalmAfter) calm = 1'b1;
               feed_block(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 2));
            end
         end
         phase++;
      end

      // drain, then watch a while for anything spurious
      req_bus.valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("** rms_audio_level_meter_unit: PASSED **");
      end else begin
         $display("** rms_audio_level_meter_unit: FAILED **");
      end
      $finish;
   end

   // hang guard, well past the slowest legal run
   initial begin
      #15_000_000;
      $display("** rms_audio_level_meter_unit: FAILED **");
      $finish;
   end

endmodule
